// ----- hw/rtl/acfr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character codes and the length decoder for the ASCII command
// frame receiver. No dependencies.
package acfr_pkg;

  // Framing characters
  localparam logic [7:0] ChStart = 8'h3A;
  localparam logic [7:0] ChEnd   = 8'h3B;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Command words, first character in the top byte
  localparam logic [31:0] WordWreg = 32'h57524547;
  localparam logic [31:0] WordRreg = 32'h52524547;
  localparam logic [23:0] WordWba  = 24'h574241;

  // Frame geometry
  localparam int unsigned HeaderLen  = 9;
  localparam int unsigned HeadLen    = 4;
  localparam int unsigned FrameLimit = 266;
  localparam int unsigned CountW     = 9;
  localparam int unsigned LenW       = 10;

  localparam logic [23:0] OwnAddrReset      = 24'h53544D;
  localparam int unsigned MaxPayloadDefault = 256;

  typedef enum logic [1:0] {
    VerdictOk       = 2'd0,
    VerdictFrameErr = 2'd1,
    VerdictUnknown  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    KindWreg = 2'd0,
    KindRreg = 2'd1,
    KindWba  = 2'd2,
    KindNone = 2'd3
  } kind_e;

  // Decoded length field: sign and magnitude (0..999)
  typedef struct packed {
    logic            neg;
    logic [LenW-1:0] mag;
  } len_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // Read three characters with atoi rules; chars[0] is the first character
  function automatic len_t decode_length(input logic [2:0][7:0] chars);
    len_t            r;
    logic            skipping;
    logic            stopped;
    logic [7:0]      c;
    logic            digit;
    logic [LenW-1:0] d;
    r        = '0;
    skipping = 1'b1;
    stopped  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c     = chars[i];
      digit = (c >= ChZero) && (c <= ChNine);
      d     = LenW'(c - ChZero);
      if (!stopped) begin
        if (skipping && is_blank(c)) begin
          skipping = 1'b1;
        end else if (skipping && ((c == ChPlus) || (c == ChMinus))) begin
          r.neg    = (c == ChMinus);
          skipping = 1'b0;
        end else if (digit) begin
          r.mag    = LenW'((r.mag << 3) + (r.mag << 1)) + d;
          skipping = 1'b0;
        end else begin
          stopped = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ascii_command_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// ASCII command frame receiver: collects one frame per colon/semicolon pair
// and issues a verdict item. Depends on acfr_pkg.
//
// Throughput: one received byte per cycle while the output register is free or
// draining, no bubbles while results drain. The verdict is in the output register
// in the cycle after the terminating semicolon is taken; decode and compare sit in that one stage.
// Reset: asynchronous, active low; clears frame tracking and the output valid
// and loads the own address with "STM". Stored characters are not cleared.
module ascii_command_frame_receiver_unit #(
  parameter int unsigned MAX_PAYLOAD = acfr_pkg::MaxPayloadDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: own address
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // verdict items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] verdict, [3:2] command_kind,
                                      // [27:4] sender_address,
                                      // [36:28] payload_length, [39:37] zero
);
  import acfr_pkg::*;

  localparam logic [LenW-1:0]   MaxLen   = LenW'(MAX_PAYLOAD);
  localparam logic [CountW-1:0] LimitCnt = CountW'(FrameLimit);
  localparam logic [CountW-1:0] HdrCnt   = CountW'(HeaderLen);
  localparam logic [CountW-1:0] HeadEnd  = CountW'(HeaderLen + HeadLen);

  logic [23:0]       own_addr_q;
  logic              in_frame_q, in_frame_d;
  logic [CountW-1:0] char_count_q, char_count_d;
  logic [7:0]        header_q [HeaderLen];
  logic [7:0]        head_q   [HeadLen];

  logic              out_valid_q;
  verdict_e          verdict_q, verdict_d;
  kind_e             kind_q, kind_d;
  logic [23:0]       sender_q, sender_d;
  logic [8:0]        plen_q, plen_d;

  logic              accept;
  logic              rx_start, rx_end;
  logic              store_byte, overflow, emit;
  logic [CountW-1:0] head_off;
  logic [23:0]       dest_addr;
  len_t              len;
  logic              len_ok;
  logic [31:0]       head_word;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OwnAddrReset;
    end else if (cfg_valid_i) begin
      own_addr_q <= cfg_data_i;
    end
  end

  // Take a byte whenever the output register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rx_start   = (s_axis_tdata == ChStart);
  assign rx_end     = (s_axis_tdata == ChEnd);
  assign store_byte = accept && in_frame_q && !rx_start;
  assign overflow   = (char_count_q == LimitCnt);
  assign emit       = store_byte && !overflow && rx_end;
  assign head_off   = char_count_q - HdrCnt;

  // Frame tracking: colon restarts, overlong frames are dropped
  always_comb begin
    in_frame_d   = in_frame_q;
    char_count_d = char_count_q;
    if (accept && rx_start) begin
      in_frame_d   = 1'b1;
      char_count_d = '0;
    end else if (store_byte) begin
      if (overflow || rx_end) begin
        in_frame_d   = 1'b0;
        char_count_d = '0;
      end else begin
        char_count_d = char_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      char_count_q <= '0;
    end else begin
      in_frame_q   <= in_frame_d;
      char_count_q <= char_count_d;
    end
  end

  // Store header and command head characters at the running position
  always_ff @(posedge clk_i) begin
    if (store_byte) begin
      if (char_count_q < HdrCnt) begin
        header_q[char_count_q[3:0]] <= s_axis_tdata;
      end else if (char_count_q < HeadEnd) begin
        head_q[head_off[1:0]] <= s_axis_tdata;
      end
    end
  end

  // Verdict from the stored characters; n is the count before the semicolon
  assign dest_addr = {header_q[3], header_q[4], header_q[5]};
  assign len       = decode_length({header_q[8], header_q[7], header_q[6]});
  assign head_word = {head_q[0], head_q[1], head_q[2], head_q[3]};
  assign len_ok    = !len.neg && (len.mag != '0) && (len.mag <= MaxLen) &&
                     ((11'(len.mag) + 11'(HeaderLen)) == 11'(char_count_q));

  always_comb begin
    verdict_d = VerdictFrameErr;
    kind_d    = KindNone;
    sender_d  = '0;
    plen_d    = '0;
    if (char_count_q > HdrCnt) begin
      sender_d = {header_q[0], header_q[1], header_q[2]};
      if ((dest_addr == own_addr_q) && len_ok) begin
        plen_d = len.mag[8:0];
        if ((len.mag >= LenW'(4)) && (head_word == WordWreg)) begin
          verdict_d = VerdictOk;
          kind_d    = KindWreg;
        end else if ((len.mag >= LenW'(4)) && (head_word == WordRreg)) begin
          verdict_d = VerdictOk;
          kind_d    = KindRreg;
        end else if ((len.mag >= LenW'(3)) && (head_word[31:8] == WordWba)) begin
          verdict_d = VerdictOk;
          kind_d    = KindWba;
        end else begin
          verdict_d = VerdictUnknown;
          kind_d    = KindNone;
        end
      end
    end
  end

  // Output register: load on a terminating semicolon, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      verdict_q <= verdict_d;
      kind_q    <= kind_d;
      sender_q  <= sender_d;
      plen_q    <= plen_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, plen_q, sender_q, kind_q, verdict_q};

`ifndef SYNTH
  // Outside a frame the character count rests at zero
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> char_count_q == '0)
    else $error("char count nonzero outside a frame");

  // The count never passes the overlong limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_count_q <= LimitCnt)
    else $error("char count beyond frame limit");

  // A frame error carries no length and no command kind
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q == VerdictFrameErr |-> plen_q == '0 && kind_q == KindNone)
    else $error("frame error with length or kind");

  // An accepted frame always names a known command
  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q == VerdictOk |-> kind_q != KindNone && plen_q != '0)
    else $error("accepted frame without command");

  // A new result follows an in-frame semicolon taken in the previous cycle
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept && in_frame_q && rx_end))
    else $error("result without terminating semicolon");
`endif

endmodule
